>>> rtl/fds_pkg.sv
// Shared types, constants and helpers of the frame difference scorer.
package fds_pkg;

  localparam int unsigned FRAME_W     = 32;
  localparam int unsigned SCORE_W     = 10;
  localparam int unsigned STEP_W      = 16;
  localparam int unsigned CNT_W       = 25;  // pixel count, up to the largest store + 1
  localparam int unsigned SUM_W       = 34;  // difference total of the largest store
  localparam int unsigned DIV_W       = 35;
  localparam int unsigned QUOT_BITS   = 10;
  localparam int unsigned QBIT_W      = 4;
  localparam int unsigned PIX_W       = 24;
  localparam int unsigned ADIFF_W     = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned SCORE_MAX   = 765;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       end_of_frame;
  } pix_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic [SCORE_W-1:0] score;
    logic               size_error;
  } result_t;

  // one finished sampled frame, waiting for its division
  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   count;
    logic               size_error;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic almost_full;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    absdiff8 = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> rtl/fds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fds_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fds_queue.sv
// Small job queue between the pixel front end and the divider back end.
module fds_queue
  import fds_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    job_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o              = entry_q[rd_ptr_q];
  assign stat_o.empty       = (cnt_q == '0);
  assign stat_o.full        = (cnt_q == CntW'(QUEUE_DEPTH));
  assign stat_o.almost_full = (cnt_q >= CntW'(QUEUE_DEPTH - 1));

endmodule

>>> rtl/fds_front.sv
// Pixel front end: frame sampling, reference compare and store, job issue.
module fds_front
  import fds_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 2097152
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pix_t              in_data_i,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_data_i,
  output logic              push_o,
  output job_t              job_o,
  input  q_stat_t           qstat_i
);

  localparam int unsigned PosW  = $clog2(MAX_PIXELS + 2);
  localparam int unsigned AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned SumW  = $clog2(64'd765 * MAX_PIXELS + 64'd1);
  localparam int unsigned MCntW = $clog2(FRAME_W);

  // frame state
  logic [PosW-1:0]    pos_q, pos_d;
  logic [FRAME_W-1:0] fc_q, fc_d;
  logic [STEP_W-1:0]  phase_q, phase_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               first_done_q, first_done_d;
  logic [PosW-1:0]    ref_size_q, ref_size_d;

  // bit-serial remainder of frame counter by period
  logic               mod_busy_q, mod_busy_d;
  logic [MCntW-1:0]   mod_cnt_q, mod_cnt_d;
  logic [STEP_W-1:0]  mod_rem_q, mod_rem_d;
  logic [STEP_W:0]    mod_shift;
  logic [STEP_W:0]    period_ext;
  logic [STEP_W-1:0]  mod_next;

  logic [STEP_W-1:0]  period;
  logic               accept;
  logic               sampled;
  logic               in_range;
  logic [PosW-1:0]    count;
  logic               size_err;

  // compare stage
  logic               s1_valid_q;
  pix_t               s1_pix_q;
  logic               s1_cmp_q;
  logic               s1_wr_q;
  logic               s1_sampled_q;
  logic               s1_err_q;
  logic               s1_fwd_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [PosW-1:0]    s1_count_q;
  logic [FRAME_W-1:0] s1_fc_q;
  logic [PIX_W-1:0]   fwd_data_q;
  logic [SumW-1:0]    sum_q, sum_d;

  logic [AddrW-1:0]   raddr;
  logic               ram_re;
  logic               ram_we;
  logic [PIX_W-1:0]   ram_wdata;
  logic [PIX_W-1:0]   ram_rdata;
  logic [PIX_W-1:0]   ref_pix;
  logic [ADIFF_W-1:0] pix_diff;
  logic [SumW-1:0]    sum_new;
  logic               fwd_d;

  assign period   = (step_q == '0) ? STEP_W'(1) : step_q;
  assign accept   = in_valid_i && !in_stall_o;
  assign sampled  = (phase_q == '0);
  assign in_range = (pos_q < PosW'(MAX_PIXELS));
  assign count    = (pos_q == PosW'(MAX_PIXELS + 1)) ? pos_q : PosW'(pos_q + 1'b1);
  assign size_err = (count > PosW'(MAX_PIXELS)) ||
                    (first_done_q && (count != ref_size_q));

  // one pending compare stage may still push, so stop one slot early
  assign in_stall_o = mod_busy_q || qstat_i.almost_full;

  assign period_ext = {1'b0, period};
  assign mod_shift  = {mod_rem_q, fc_q[MCntW'(FRAME_W - 1) - mod_cnt_q]};
  assign mod_next   = (mod_shift >= period_ext) ? STEP_W'(mod_shift - period_ext)
                                                : mod_shift[STEP_W-1:0];

  always_comb begin
    pos_d        = pos_q;
    fc_d         = fc_q;
    phase_d      = phase_q;
    step_d       = step_q;
    first_done_d = first_done_q;
    ref_size_d   = ref_size_q;
    mod_busy_d   = mod_busy_q;
    mod_cnt_d    = mod_cnt_q;
    mod_rem_d    = mod_rem_q;

    if (accept) begin
      if (in_data_i.end_of_frame) begin
        pos_d = '0;
        fc_d  = fc_q + 1'b1;
        if (fc_q == '1 || phase_q == STEP_W'(period - 1'b1)) begin
          phase_d = '0;
        end else begin
          phase_d = STEP_W'(phase_q + 1'b1);
        end
        if (!first_done_q) begin
          ref_size_d   = count;
          first_done_d = 1'b1;
        end
      end else begin
        pos_d = count;
      end
    end

    if (cfg_we_i) begin
      step_d     = cfg_data_i;
      mod_busy_d = 1'b1;
      mod_cnt_d  = '0;
      mod_rem_d  = '0;
    end else if (mod_busy_q) begin
      mod_rem_d = mod_next;
      mod_cnt_d = MCntW'(mod_cnt_q + 1'b1);
      if (mod_cnt_q == MCntW'(FRAME_W - 1)) begin
        mod_busy_d = 1'b0;
        phase_d    = mod_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      fc_q         <= '0;
      phase_q      <= '0;
      step_q       <= STEP_W'(1);
      first_done_q <= 1'b0;
      ref_size_q   <= '0;
      mod_busy_q   <= 1'b0;
      mod_cnt_q    <= '0;
      mod_rem_q    <= '0;
      s1_valid_q   <= 1'b0;
      sum_q        <= '0;
    end else begin
      pos_q        <= pos_d;
      fc_q         <= fc_d;
      phase_q      <= phase_d;
      step_q       <= step_d;
      first_done_q <= first_done_d;
      ref_size_q   <= ref_size_d;
      mod_busy_q   <= mod_busy_d;
      mod_cnt_q    <= mod_cnt_d;
      mod_rem_q    <= mod_rem_d;
      s1_valid_q   <= accept;
      sum_q        <= sum_d;
    end
  end

  // read-during-write: a one-pixel frame rereads the entry just written
  assign raddr  = pos_q[AddrW-1:0];
  assign ram_re = accept && sampled && in_range;
  assign fwd_d  = s1_valid_q && s1_wr_q && (s1_addr_q == raddr);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q     <= in_data_i;
      s1_cmp_q     <= sampled && in_range && first_done_q;
      s1_wr_q      <= sampled && in_range;
      s1_sampled_q <= sampled;
      s1_err_q     <= size_err;
      s1_fwd_q     <= fwd_d;
      s1_addr_q    <= raddr;
      s1_count_q   <= count;
      s1_fc_q      <= fc_q;
    end
    if (ram_we) begin
      fwd_data_q <= ram_wdata;
    end
  end

  assign ram_we    = s1_valid_q && s1_wr_q;
  assign ram_wdata = {s1_pix_q.red, s1_pix_q.green, s1_pix_q.blue};
  assign ref_pix   = s1_fwd_q ? fwd_data_q : ram_rdata;

  fds_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign pix_diff = ADIFF_W'(absdiff8(s1_pix_q.blue,  ref_pix[7:0]))
                  + ADIFF_W'(absdiff8(s1_pix_q.green, ref_pix[15:8]))
                  + ADIFF_W'(absdiff8(s1_pix_q.red,   ref_pix[23:16]));
  assign sum_new  = s1_cmp_q ? SumW'(sum_q + SumW'(pix_diff)) : sum_q;

  always_comb begin
    sum_d = sum_q;
    if (s1_valid_q) begin
      sum_d = s1_pix_q.end_of_frame ? '0 : sum_new;
    end
  end

  assign push_o            = s1_valid_q && s1_pix_q.end_of_frame && s1_sampled_q;
  assign job_o.frame_index = s1_fc_q;
  assign job_o.sum         = SUM_W'(sum_new);
  assign job_o.count       = CNT_W'(s1_count_q);
  assign job_o.size_error  = s1_err_q;

  a_push_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !qstat_i.full)
    else $error("job push into a full queue");

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mod_busy_q |-> (phase_q < period))
    else $error("frame phase out of range");

  a_pos_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MAX_PIXELS + 1))
    else $error("pixel position beyond saturation");

endmodule

>>> rtl/fds_back.sv
// Back end: restoring divider for the frame score and the output register.
module fds_back
  import fds_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  job_t    job_i,
  input  q_stat_t qstat_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  back_state_e          state_q, state_d;
  job_t                 job_q;
  logic [DIV_W-1:0]     rem_q;
  logic [QUOT_BITS-1:0] quo_q;
  logic [QBIT_W-1:0]    bit_q;
  logic                 out_valid_q;
  result_t              out_data_q;

  logic                 out_free;
  logic                 div_en;
  logic                 load_out;
  logic [DIV_W-1:0]     trial;
  logic                 fits;

  assign out_free = !out_valid_q || !out_stall_i;
  assign trial    = DIV_W'(job_q.count) << bit_q;
  assign fits     = (rem_q >= trial);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (bit_q == '0) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    div_en   = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: pop_o    = !qstat_i.empty;
      BK_DIV:  div_en   = 1'b1;
      BK_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // quotient is known to fit in ten bits, so start at bit nine
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      rem_q <= DIV_W'(job_i.sum);
      quo_q <= '0;
      bit_q <= QBIT_W'(QUOT_BITS - 1);
    end else if (div_en) begin
      if (fits) begin
        rem_q        <= DIV_W'(rem_q - trial);
        quo_q[bit_q] <= 1'b1;
      end
      bit_q <= QBIT_W'(bit_q - 1'b1);
    end
    if (load_out) begin
      out_data_q.frame_index <= job_q.frame_index;
      out_data_q.score       <= job_q.size_error ? '0 : quo_q;
      out_data_q.size_error  <= job_q.size_error;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_score_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !job_q.size_error) |-> (quo_q <= QUOT_BITS'(SCORE_MAX)))
    else $error("score above three channel maximum");

endmodule

>>> rtl/frame_difference_scorer_top.sv
// Top level of the frame difference scorer.
//
// Scores a BGR pixel stream by mean absolute difference against a stored
// reference frame. Pixels are taken one per cycle while in_stall_o is low.
// Every frame whose index is a multiple of sample_step is compared pixel by
// pixel and then becomes the new reference; at its last pixel one result
// carries the frame index and floor(total / pixel_count), or size_error with
// a score of 0. Each sampled frame end goes to the back-end restoring divider
// through a 4-entry job queue; runs of very short frames or a stalled output
// can fill it and stall the input. A write to sample_step stalls the input
// while a bit-serial remainder unit recomputes the frame phase. The reference
// store is a single RAM of MAX_PIXELS 24-bit entries, read and written once
// per sampled pixel that fits in it; it is not cleared after reset.
module frame_difference_scorer_top
  import fds_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 2097152
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pix_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output result_t           out_data_o,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_data_i
);

  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head_job;
  q_stat_t qstat;

  fds_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .job_o      (push_job),
    .qstat_i    (qstat)
  );

  fds_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (qstat)
  );

  fds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/tb_frame_difference_scorer_top.sv
// Testbench for frame_difference_scorer_top: random BGR frames checked against a frame-score model.
module tb_frame_difference_scorer_top;
  import fds_pkg::*;

  localparam int unsigned MAX_PIX        = 4;     // small store so every case is reachable
  localparam int unsigned PHASE_ITEMS    = 130;
  localparam int unsigned SETTLE_CYCLES  = 80;    // divider queue plus step recompute
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {
    FILL_CONST,
    FILL_NOISE,
    FILL_NEAR,
    FILL_EXTREME
  } fill_e;

  // Tracks reference frame, running total and frame count; queues expected scores.
  class frame_score_model;
    logic [23:0]       ref_pix [MAX_PIX];
    longint unsigned   diff_total;
    longint unsigned   pos;
    logic [31:0]       frame_no;
    longint unsigned   ref_count;
    bit                first_done;
    logic [STEP_W-1:0] step;
    result_t           pending_scores[$];
    int unsigned       mismatches;
    int unsigned       scores_expected;

    function new();
      foreach (ref_pix[i]) ref_pix[i] = '0;
      diff_total      = 0;
      pos             = 0;
      frame_no        = '0;
      ref_count       = 0;
      first_done      = 1'b0;
      step            = 16'd1;
      mismatches      = 0;
      scores_expected = 0;
    endfunction

    function automatic longint unsigned chan_diff(logic [7:0] a, logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return {56'd0, d};
    endfunction

    function void set_step(logic [STEP_W-1:0] v);
      step = v;
    endfunction

    function void take_pixel(pix_t px);
      logic [31:0]     period;
      bit              sampled;
      bit              err;
      longint unsigned count;
      longint unsigned quot;
      logic [23:0]     old;
      result_t         want;
      period  = (step == '0) ? 32'd1 : {16'd0, step};
      sampled = (frame_no % period) == 32'd0;
      if (sampled && pos < MAX_PIX) begin
        old = ref_pix[pos];
        if (first_done) begin
          diff_total += chan_diff(px.blue, old[7:0]) + chan_diff(px.green, old[15:8])
                      + chan_diff(px.red, old[23:16]);
        end
        ref_pix[pos] = {px.red, px.green, px.blue};
      end
      // count saturates one above the store size
      count = (pos + 1 > MAX_PIX + 1) ? MAX_PIX + 1 : pos + 1;
      if (!px.end_of_frame) begin
        pos = count;
        return;
      end
      if (sampled) begin
        err  = (count > MAX_PIX) || (first_done && count != ref_count);
        quot = err ? 0 : diff_total / count;
        want.frame_index = frame_no;
        want.score       = quot[SCORE_W-1:0];
        want.size_error  = err;
        pending_scores   = {pending_scores, want};
        scores_expected++;
      end
      if (!first_done) begin
        ref_count  = count;
        first_done = 1'b1;
      end
      diff_total = 0;
      pos        = 0;
      frame_no   = frame_no + 32'd1;
    endfunction

    function void check_score(result_t got);
      result_t want;
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result: frame_index %0d score %0d size_error %0d",
                 $time, got.frame_index, got.score, got.size_error);
        mismatches++;
        return;
      end
      want = pending_scores.pop_front();
      if (got.frame_index !== want.frame_index) begin
        $display("%0t: frame_index expected %0d, actual %0d",
                 $time, want.frame_index, got.frame_index);
        mismatches++;
      end
      if (got.score !== want.score) begin
        $display("%0t: score of frame %0d expected %0d, actual %0d",
                 $time, want.frame_index, want.score, got.score);
        mismatches++;
      end
      if (got.size_error !== want.size_error) begin
        $display("%0t: size_error of frame %0d expected %0d, actual %0d",
                 $time, want.frame_index, want.size_error, got.size_error);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  pix_t              in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  result_t           out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [STEP_W-1:0] cfg_data_i  = '0;

  frame_score_model scorer_model = new();

  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_left  = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  logic [STEP_W-1:0] step_plan [8] = '{16'd1, 16'd3, 16'd65535, 16'd2,
                                       16'd0, 16'd1, 16'd7, 16'd1};
  int unsigned gap_plan   [4] = '{0, 59, 0, 17};
  int unsigned stall_plan [4] = '{0, 0, 59, 17};

  frame_difference_scorer_top #(
    .MAX_PIXELS(MAX_PIX)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // transfers and register writes feed the model in clock order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) scorer_model.set_step(cfg_data_i);
      if (in_valid_i && !in_stall_o) scorer_model.take_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) scorer_model.check_score(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_pixel(input pix_t px);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_frame(input int unsigned npix, input fill_e fill,
                            input logic [7:0] level, input bit close);
    pix_t       px;
    logic [7:0] b0;
    logic [7:0] g0;
    logic [7:0] r0;
    b0 = 8'($urandom);
    g0 = 8'($urandom);
    r0 = 8'($urandom);
    for (int unsigned i = 0; i < npix; i++) begin
      case (fill)
        FILL_CONST: begin
          px.blue  = level;
          px.green = level;
          px.red   = level;
        end
        FILL_NEAR: begin
          px.blue  = b0 + 8'($urandom_range(7));
          px.green = g0 + 8'($urandom_range(7));
          px.red   = r0 + 8'($urandom_range(7));
        end
        FILL_EXTREME: begin
          px.blue  = {8{1'($urandom)}};
          px.green = {8{1'($urandom)}};
          px.red   = {8{1'($urandom)}};
        end
        default: begin
          px.blue  = 8'($urandom);
          px.green = 8'($urandom);
          px.red   = 8'($urandom);
        end
      endcase
      px.end_of_frame = close && (i == npix - 1);
      send_pixel(px);
    end
  endtask

  // sender pauses until every expected score is back, then lets the back end go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (scorer_model.pending_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned   sel;
    int unsigned   npix;
    int unsigned   phase_end;
    fill_e         fill;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first frame fills the whole store and scores 0, with nothing to compare against
    send_frame(MAX_PIX, FILL_CONST, 8'h00, 1'b1);
    send_frame(MAX_PIX, FILL_CONST, 8'hff, 1'b1);     // full-scale difference
    send_frame(1, FILL_NOISE, 8'h00, 1'b1);           // size mismatch
    send_frame(MAX_PIX + 2, FILL_NOISE, 8'h00, 1'b1); // larger than the store
    settle();
    write_step(16'd0);                                // zero step behaves as one
    send_frame(MAX_PIX, FILL_NOISE, 8'h00, 1'b1);
    send_frame(MAX_PIX / 2, FILL_NOISE, 8'h00, 1'b0);
    settle();
    write_step(16'd7);                                // step changes inside a frame
    send_frame(MAX_PIX / 2, FILL_NOISE, 8'h00, 1'b1);
    settle();

    for (int unsigned p = 0; p < 8; p++) begin
      gap_pct   = gap_plan[p % 4];
      stall_pct = stall_plan[p % 4];
      write_step(step_plan[p % 8]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        sel  = $urandom_range(99);
        npix = (sel < 75) ? MAX_PIX :
               (sel < 88) ? $urandom_range(MAX_PIX - 1, 1) :
                            $urandom_range(MAX_PIX + 3, MAX_PIX + 1);
        fill = fill_e'($urandom_range(3));
        send_frame(npix, fill, 8'($urandom), 1'b1);
      end
      if (p == 0) begin
        // receiver holds off while one-pixel frames pile up behind the divider
        hold_left = HOLD_CYCLES;
        repeat (12) send_frame(1, FILL_NOISE, 8'h00, 1'b1);
      end
      settle();
    end

    settle();
    if (scorer_model.mismatches == 0 && scorer_model.pending_scores.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
